FILE: hdl/ndwg_pkg.sv
// ----------------------------------------------------------------------------
// Noise dominance window gate package
// Shared types and constants for the window cells, the judging logic and the
// core.
// ----------------------------------------------------------------------------
package ndwg_pkg;

  localparam int MaxWindow = 25;
  localparam int CntW      = $clog2(MaxWindow + 1);
  localparam int LenW      = 5;
  localparam int MinW      = 5;
  localparam int ShareW    = 7;
  localparam int NeedW     = 8;
  localparam int CfgDataW  = 8;
  localparam int CfgIdxW   = 2;
  localparam int ProdW     = CntW + ShareW + 1;
  localparam int FullShare = 100;

  localparam logic [LenW-1:0]   ResetWindowLength = LenW'(15);
  localparam logic [MinW-1:0]   ResetMinEnergetic = MinW'(5);
  localparam logic [ShareW-1:0] ResetNoiseShare   = ShareW'(80);
  localparam logic [NeedW-1:0]  ResetConfirmNeed  = NeedW'(5);

  typedef enum logic [1:0] {
    CLASS_QUIET     = 2'd0,
    CLASS_ENERGETIC = 2'd1,
    CLASS_NOISY     = 2'd2
  } class_e;

  typedef enum logic [0:0] {
    OP_OBSERVE = 1'b0,
    OP_CLEAR   = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_MIN_ENERGETIC = 2'd1,
    REG_NOISE_SHARE   = 2'd2,
    REG_CONFIRM_NEED  = 2'd3
  } reg_e;

  typedef struct packed {
    logic observe;
    logic wipe;
    logic energetic;
    logic suspected;
    logic candidate;
    logic segment;
  } ctl_t;

  typedef struct packed {
    logic veto;
    logic dominant;
  } result_t;

endpackage

FILE: hdl/ndwg_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds the class of one frame of the sliding window, passes it to the next
// cell on every observed frame and offers it to the eviction tap chain.
// ----------------------------------------------------------------------------
module ndwg_cell
  import ndwg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  logic   clear_i,
  input  logic   sel_i,
  input  class_e class_i,
  input  class_e tap_i,
  output class_e class_o,
  output class_e tap_o
);

  class_e class_d, class_q;

  always_comb begin
    class_d = class_q;
    if (clear_i) begin
      class_d = CLASS_QUIET;
    end else if (shift_i) begin
      class_d = class_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= CLASS_QUIET;
    end else begin
      class_q <= class_d;
    end
  end

  assign class_o = class_q;
  assign tap_o   = sel_i ? class_q : tap_i;

endmodule

FILE: hdl/ndwg_judge.sv
// ----------------------------------------------------------------------------
// Dominance judge
// Keeps the running energetic and noisy counts and the confirm run, and
// decides dominance and veto for the frame being observed.
// ----------------------------------------------------------------------------
module ndwg_judge
  import ndwg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  input  class_e            new_class_i,
  input  class_e            old_class_i,
  input  logic [MinW-1:0]   min_energetic_i,
  input  logic [ShareW-1:0] noise_share_i,
  input  logic [NeedW-1:0]  confirm_need_i,
  output result_t           result_o
);

  logic [CntW-1:0]  energetic_d, energetic_q;
  logic [CntW-1:0]  noisy_d, noisy_q;
  logic [NeedW-1:0] run_d, run_q;
  logic [CntW-1:0]  energetic_new, noisy_new;
  logic [NeedW-1:0] run_new;
  logic [ProdW-1:0] noisy_scaled, energetic_scaled;
  logic             dom, dom_flag;

  always_comb begin
    energetic_new = energetic_q - CntW'(old_class_i != CLASS_QUIET)
                    + CntW'(new_class_i != CLASS_QUIET);
    noisy_new     = noisy_q - CntW'(old_class_i == CLASS_NOISY)
                    + CntW'(new_class_i == CLASS_NOISY);

    noisy_scaled     = ProdW'(noisy_new) * ProdW'(FullShare);
    energetic_scaled = ProdW'(energetic_new) * ProdW'(noise_share_i);

    dom = (ProdW'(energetic_new) >= ProdW'(min_energetic_i)) &&
          (noisy_scaled >= energetic_scaled);

    if (!dom || ctl_i.candidate) begin
      run_new = '0;
    end else if (run_q < confirm_need_i) begin
      run_new = run_q + NeedW'(1);
    end else begin
      run_new = run_q;
    end

    dom_flag = dom && !ctl_i.candidate;

    result_o.dominant = dom_flag;
    result_o.veto     = ctl_i.energetic && ctl_i.suspected && dom_flag &&
                        (!ctl_i.segment || (run_new >= confirm_need_i));
  end

  always_comb begin
    energetic_d = energetic_q;
    noisy_d     = noisy_q;
    run_d       = run_q;
    if (ctl_i.wipe) begin
      energetic_d = '0;
      noisy_d     = '0;
      run_d       = '0;
    end else if (ctl_i.observe) begin
      energetic_d = energetic_new;
      noisy_d     = noisy_new;
      run_d       = run_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energetic_q <= '0;
      noisy_q     <= '0;
      run_q       <= '0;
    end else begin
      energetic_q <= energetic_d;
      noisy_q     <= noisy_d;
      run_q       <= run_d;
    end
  end

endmodule

FILE: hdl/noise_dominance_window_gate_core.sv
// ----------------------------------------------------------------------------
// Noise dominance window gate core
// Output: a result is registered and offered in the cycle after acceptance.
// Throughput: one frame per cycle; the count update and the dominance
// compare in the judge complete within that cycle. A new frame is accepted
// in the cycle in which the waiting result is taken, and a stalled result
// holds off the input until it is taken.
// Reset: asynchronous, active low; window, counts and confirm run clear and
// the configuration registers take their default values.
// ----------------------------------------------------------------------------
module noise_dominance_window_gate_core
  import ndwg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic                frame_energetic_i,
  input  logic                noise_suspected_i,
  input  logic                speech_candidate_i,
  input  logic                in_segment_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                veto_o,
  output logic                dominant_o,
  output logic                config_bad_o
);

  logic [LenW-1:0]   win_len_d, win_len_q;
  logic [MinW-1:0]   min_en_d, min_en_q;
  logic [ShareW-1:0] share_d, share_q;
  logic [NeedW-1:0]  need_d, need_q;

  logic    cfg_ok, accept, len_write;
  ctl_t    ctl;
  class_e  new_class;
  result_t result;

  logic out_valid_d, out_valid_q;
  logic veto_d, veto_q, dom_d, dom_q, bad_d, bad_q;

  class_e chain_class [MaxWindow+1];
  class_e chain_tap   [MaxWindow+1];

  always_comb begin
    win_len_d = win_len_q;
    min_en_d  = min_en_q;
    share_d   = share_q;
    need_d    = need_q;
    if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_WINDOW_LENGTH: win_len_d = cfg_wdata_i[LenW-1:0];
        REG_MIN_ENERGETIC: min_en_d  = cfg_wdata_i[MinW-1:0];
        REG_NOISE_SHARE:   share_d   = cfg_wdata_i[ShareW-1:0];
        REG_CONFIRM_NEED:  need_d    = cfg_wdata_i[NeedW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= ResetWindowLength;
      min_en_q  <= ResetMinEnergetic;
      share_q   <= ResetNoiseShare;
      need_q    <= ResetConfirmNeed;
    end else begin
      win_len_q <= win_len_d;
      min_en_q  <= min_en_d;
      share_q   <= share_d;
      need_q    <= need_d;
    end
  end

  assign cfg_ok = (win_len_q != '0) && (32'(win_len_q) <= MaxWindow) &&
                  (min_en_q != '0) && (min_en_q <= win_len_q) &&
                  (share_q != '0) && (32'(share_q) <= FullShare) &&
                  (need_q != '0);

  assign len_write  = cfg_we_i && (reg_e'(cfg_idx_i) == REG_WINDOW_LENGTH);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ctl.observe   = accept && (op_e'(opcode_i) == OP_OBSERVE) && cfg_ok;
    ctl.wipe      = (accept && ((op_e'(opcode_i) == OP_CLEAR) || !cfg_ok)) ||
                    len_write;
    ctl.energetic = frame_energetic_i;
    ctl.suspected = noise_suspected_i;
    ctl.candidate = speech_candidate_i;
    ctl.segment   = in_segment_i;
  end

  always_comb begin
    if (!frame_energetic_i) begin
      new_class = CLASS_QUIET;
    end else if (noise_suspected_i) begin
      new_class = CLASS_NOISY;
    end else begin
      new_class = CLASS_ENERGETIC;
    end
  end

  assign chain_class[0]       = new_class;
  assign chain_tap[MaxWindow] = CLASS_QUIET;

  for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
    ndwg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctl.observe),
      .clear_i (ctl.wipe),
      .sel_i   (win_len_q == LenW'(i + 1)),
      .class_i (chain_class[i]),
      .tap_i   (chain_tap[i+1]),
      .class_o (chain_class[i+1]),
      .tap_o   (chain_tap[i])
    );
  end

  ndwg_judge u_judge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .new_class_i     (new_class),
    .old_class_i     (chain_tap[0]),
    .min_energetic_i (min_en_q),
    .noise_share_i   (share_q),
    .confirm_need_i  (need_q),
    .result_o        (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    veto_d      = veto_q;
    dom_d       = dom_q;
    bad_d       = bad_q;
    if (accept) begin
      out_valid_d = 1'b1;
      veto_d      = ctl.observe && result.veto;
      dom_d       = ctl.observe && result.dominant;
      bad_d       = !cfg_ok;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    veto_q <= veto_d;
    dom_q  <= dom_d;
    bad_q  <= bad_d;
  end

  assign out_valid_o  = out_valid_q;
  assign veto_o       = veto_q;
  assign dominant_o   = dom_q;
  assign config_bad_o = bad_q;

endmodule
